### rtl/dcc_pkg.sv
// Shared types, codes and helpers of the disk controller command port.
`timescale 1ns / 1ps
package dcc_pkg;

  localparam int unsigned NDRV = 2;
  localparam int unsigned DRIVES_PER_BOARD = 2;

  // transfer kinds
  localparam logic [2:0] K_DATA_WR = 3'd0;
  localparam logic [2:0] K_DATA_RD = 3'd1;
  localparam logic [2:0] K_STAT_RD = 3'd2;
  localparam logic [2:0] K_SEL_WR  = 3'd3;
  localparam logic [2:0] K_RST_WR  = 3'd4;
  localparam logic [2:0] K_DELAY   = 3'd5;

  // handshake status bits
  localparam logic [5:0] ST_READY     = 6'h01;
  localparam logic [5:0] ST_INPUT     = 6'h02;
  localparam logic [5:0] ST_COMMAND   = 6'h04;
  localparam logic [5:0] ST_SELECT    = 6'h08;
  localparam logic [5:0] ST_REQUEST   = 6'h10;
  localparam logic [5:0] ST_INTERRUPT = 6'h20;

  localparam logic [7:0] SB_ERROR  = 8'h02;
  localparam logic [7:0] SB_DRIVE1 = 8'h20;
  localparam logic [7:0] EC_SENSE  = 8'h80;
  localparam logic [7:0] EC_NREADY = 8'h04;
  localparam logic [7:0] EC_BADCMD = 8'h20;

  // command opcodes
  localparam logic [7:0] C_TEST   = 8'h00;
  localparam logic [7:0] C_RECAL  = 8'h01;
  localparam logic [7:0] C_SENSE  = 8'h03;
  localparam logic [7:0] C_FMTDRV = 8'h04;
  localparam logic [7:0] C_VERIFY = 8'h05;
  localparam logic [7:0] C_FMTTRK = 8'h06;
  localparam logic [7:0] C_FMTBAD = 8'h07;
  localparam logic [7:0] C_READ   = 8'h08;
  localparam logic [7:0] C_WRITE  = 8'h0a;
  localparam logic [7:0] C_SEEK   = 8'h0b;
  localparam logic [7:0] C_SETPAR = 8'h0c;
  localparam logic [7:0] C_GETECC = 8'h0d;
  localparam logic [7:0] C_RDDIAG = 8'he3;
  localparam logic [7:0] C_RDLONG = 8'he5;
  localparam logic [7:0] C_WRLONG = 8'he6;

  // APB register indexes
  localparam logic [1:0] R_PRESENT = 2'd0;
  localparam logic [1:0] R_DIP     = 2'd1;
  localparam logic [1:0] R_SPT     = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] wdata;
    logic       pio;
    logic       known;
  } op_t;

  typedef struct packed {
    logic [1:0] drive_present;
    logic [7:0] dip_switches;
    logic [5:0] spt;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_pulse;
    logic [2:0]  irq_level;
    logic        xfer_start;
    logic        xfer_write;
    logic        xfer_pio;
    logic        xfer_drive;
    logic [20:0] xfer_sector;
    logic [7:0]  xfer_count;
  } res_t;

  function automatic logic cmd_known(input logic [7:0] v);
    if (v <= 8'h0f) return (v != 8'h02) && (v != 8'h09);
    return (v == 8'he0) || ((v >= 8'he3) && (v <= 8'he6));
  endfunction

endpackage

### rtl/disk_controller_command_port.sv
// Top level of the disk controller command port: stream ports, APB registers.
`timescale 1ns / 1ps
// Timing: each item is registered in the front queue, then in the result register; a
//   read/write command that issues a sector transfer also passes S_MUL1, S_MUL2 and
//   S_ADD (two multiply stages and an add). Throughput: one item per cycle unless the
//   result stream stalls; the back end's single executor takes none in those states.
// Reset (rst, synchronous, active high): queue empty, no result held, status
//   bits 0x05, drive geometry 612 cylinders / 4 heads / ECC 11, registers to
//   drive_present 0, dip_switches 0xff, sectors_per_track 17.
module disk_controller_command_port (
  input  logic        clk,
  input  logic        rst,
  // host access stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] write_data, [8] dma_masked, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] read_data, [8] irq_pulse, [11:9] irq_level,
                                 // [12] xfer_start, [13] xfer_write, [14] xfer_pio,
                                 // [15] xfer_drive, [36:16] xfer_sector,
                                 // [44:37] xfer_count, rest zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dcc_pkg::*;

  cfg_t cfg;
  op_t  op;
  res_t res;
  logic op_valid, op_pop;

  // APB: always ready, register written on the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_present <= 2'd0;
      cfg.dip_switches  <= 8'hff;
      cfg.spt           <= 6'd17;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        R_PRESENT: cfg.drive_present <= pwdata[1:0];
        R_DIP:     cfg.dip_switches  <= pwdata[7:0];
        R_SPT:     cfg.spt           <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      R_PRESENT: prdata = {30'd0, cfg.drive_present};
      R_DIP:     prdata = {24'd0, cfg.dip_switches};
      R_SPT:     prdata = {26'd0, cfg.spt};
      default:   prdata = 32'd0;
    endcase
  end

  // front: classify each transfer and hold it in a two-entry queue
  dcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_wdata (s_tdata[7:0]),
    .in_pio   (s_tdata[8]),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  // back: executes one item at a time into the result register
  dcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op_valid  (op_valid),
    .op        (op),
    .op_pop    (op_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {3'd0, res.xfer_count, res.xfer_sector, res.xfer_drive, res.xfer_pio,
                    res.xfer_write, res.xfer_start, res.irq_level, res.irq_pulse,
                    res.read_data};

endmodule

### rtl/dcc_front.sv
// Front end: accepts host transfers, classifies them and queues them two deep.
`timescale 1ns / 1ps
module dcc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2:0]     in_kind,
  input  logic [7:0]     in_wdata,
  input  logic           in_pio,
  output logic           op_valid,
  output dcc_pkg::op_t   op,
  input  logic           op_pop
);
  import dcc_pkg::*;

  op_t        q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign op_valid = (count != 2'd0);
  assign op       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (op_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, op_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].kind  <= in_kind;
      q[wr_ptr].wdata <= in_wdata;
      q[wr_ptr].pio   <= in_pio;
      q[wr_ptr].known <= cmd_known(in_wdata);
    end
  end

endmodule

### rtl/dcc_back.sv
// Back end: command block state, command execution and the result register.
`timescale 1ns / 1ps
module dcc_back (
  input  logic           clk,
  input  logic           rst,
  input  dcc_pkg::cfg_t  cfg,
  input  logic           op_valid,
  input  dcc_pkg::op_t   op,
  output logic           op_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output dcc_pkg::res_t  res
);
  import dcc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_ADD  = 2'd3;

  logic [1:0]  st;
  logic [5:0]  status_bits, status_bits_next;
  logic [7:0]  cmd_bytes [14];
  logic [7:0]  cmd_bytes_next [14];
  logic [7:0]  res_bytes [5];
  logic [7:0]  res_bytes_next [5];
  logic [3:0]  bytes_left, bytes_left_next;
  logic [3:0]  byte_ptr, byte_ptr_next;
  logic        cmd_wait, cmd_wait_next;
  logic [7:0]  status_byte, status_byte_next;
  logic [7:0]  error_code, error_code_next;
  logic        sel, sel_next;
  logic [9:0]  drive_cyl [NDRV];
  logic [9:0]  drive_cyl_next [NDRV];
  logic [4:0]  drive_heads [NDRV];
  logic [4:0]  drive_heads_next [NDRV];
  logic [7:0]  ecc_len [NDRV];
  logic [7:0]  ecc_len_next [NDRV];
  logic [9:0]  cur_cyl [NDRV];
  logic [9:0]  cur_cyl_next [NDRV];
  logic [4:0]  cur_head [NDRV];
  logic [4:0]  cur_head_next [NDRV];
  logic [5:0]  cur_sec [NDRV];
  logic [5:0]  cur_sec_next [NDRV];
  logic [7:0]  cur_cnt [NDRV];
  logic [7:0]  cur_cnt_next [NDRV];
  res_t        res_next;
  logic [14:0] p1;
  logic [21:0] p2;

  assign op_pop = op_valid && (st == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    logic [7:0] c0;
    logic       pos, test, xfer, wr, valid, ecc, rdy;
    logic [2:0] n;
    status_bits_next = status_bits;
    cmd_bytes_next   = cmd_bytes;
    res_bytes_next   = res_bytes;
    bytes_left_next  = bytes_left;
    byte_ptr_next    = byte_ptr;
    cmd_wait_next    = cmd_wait;
    status_byte_next = status_byte;
    error_code_next  = error_code;
    sel_next         = sel;
    drive_cyl_next   = drive_cyl;
    drive_heads_next = drive_heads;
    ecc_len_next     = ecc_len;
    cur_cyl_next     = cur_cyl;
    cur_head_next    = cur_head;
    cur_sec_next     = cur_sec;
    cur_cnt_next     = cur_cnt;
    res_next           = '0;
    res_next.read_data = 8'hff;
    res_next.irq_level = cfg.dip_switches[6] ? 3'd5 : 3'd2;
    c0 = cmd_bytes[0];
    pos = 1'b1; test = 1'b1; xfer = 1'b0; wr = 1'b0; valid = 1'b1; ecc = 1'b0;
    rdy = 1'b0;
    n = 3'd0;
    case (op.kind)
      K_DATA_WR: begin
        if (!(bytes_left != 4'd0 && (status_bits & ST_INPUT) != 6'd0)) begin
          if (bytes_left == 4'd0) begin
            cmd_wait_next    = 1'b0;
            byte_ptr_next    = 4'd0;
            status_bits_next = status_bits_next & ~(ST_READY | ST_INPUT);
            if (!op.known) begin
              status_byte_next  = SB_ERROR | EC_BADCMD;
              error_code_next   = EC_BADCMD;
              res_bytes_next[0] = SB_ERROR | EC_BADCMD;
              res_bytes_next[1] = EC_BADCMD;
              bytes_left_next   = 4'd2;
              status_bits_next  = status_bits_next | ST_INTERRUPT | ST_INPUT | ST_REQUEST
                                  | ST_COMMAND | ST_READY;
            end else begin
              bytes_left_next  = (op.wdata == C_SETPAR) ? 4'd14 : 4'd6;
              status_bits_next = status_bits_next | ST_REQUEST;
            end
          end
          if (bytes_left != 4'd0 || op.known) begin
            if (byte_ptr_next < 4'd14) cmd_bytes_next[byte_ptr_next] = op.wdata;
            byte_ptr_next    = byte_ptr_next + 4'd1;
            status_bits_next = status_bits_next | ST_READY;
            bytes_left_next  = bytes_left_next - 4'd1;
            if (bytes_left_next == 4'd0) begin
              status_bits_next = (status_bits_next & ~(ST_COMMAND | ST_REQUEST | ST_READY))
                                 | ST_INPUT;
              cmd_wait_next    = 1'b1;
            end
          end
        end
      end
      K_DATA_RD: begin
        if (bytes_left != 4'd0 && (status_bits & ST_INPUT) != 6'd0) begin
          res_next.read_data = (byte_ptr < 4'd5) ? res_bytes[byte_ptr[2:0]] : 8'hff;
          byte_ptr_next    = byte_ptr + 4'd1;
          status_bits_next = status_bits & ~ST_INTERRUPT;
          bytes_left_next  = bytes_left - 4'd1;
          if (bytes_left_next == 4'd0)
            status_bits_next = (status_bits_next & ~(ST_INPUT | ST_REQUEST | ST_SELECT))
                               | ST_COMMAND;
        end
      end
      K_STAT_RD: res_next.read_data = {2'b00, status_bits};
      K_SEL_WR:  status_bits_next = (status_bits & ~ST_INTERRUPT) | ST_SELECT;
      K_RST_WR: begin
        for (int i = 0; i < NDRV; i++) begin
          cur_cyl_next[i]  = '0;
          cur_head_next[i] = '0;
          cur_sec_next[i]  = '0;
        end
        status_byte_next = 8'd0;
        status_bits_next = ST_COMMAND | ST_READY;
        bytes_left_next  = 4'd0;
        byte_ptr_next    = 4'd0;
        cmd_wait_next    = 1'b0;
      end
      K_DELAY: begin
        if (cmd_wait) begin
          cmd_wait_next    = 1'b0;
          status_byte_next = 8'd0;
          error_code_next  = 8'd0;
          case (c0)
            C_TEST, C_SENSE: pos = 1'b0;
            C_RECAL, C_SETPAR: test = 1'b0;
            C_FMTDRV, C_VERIFY, C_FMTTRK, C_FMTBAD, C_SEEK, C_RDDIAG: ;
            C_READ, C_RDLONG: xfer = 1'b1;
            C_WRITE, C_WRLONG: begin xfer = 1'b1; wr = 1'b1; end
            C_GETECC: begin ecc = 1'b1; pos = 1'b0; test = 1'b0; valid = 1'b0; end
            default: begin pos = 1'b0; test = 1'b0; valid = 1'b0; end
          endcase
          if (ecc) begin
            res_bytes_next[0] = ecc_len[sel];
            n = 3'd1;
          end
          if (valid) begin
            sel_next = cmd_bytes[1][5];
            status_byte_next = sel_next ? SB_DRIVE1 : 8'd0;
            if (pos) begin
              cur_head_next[sel_next] = cmd_bytes[1][4:0];
              cur_sec_next[sel_next]  = cmd_bytes[2][5:0];
              cur_cyl_next[sel_next]  = {cmd_bytes[2][7:6], cmd_bytes[3]};
              cur_cnt_next[sel_next]  = cmd_bytes[4];
              error_code_next         = EC_SENSE;
            end
            if (c0 == C_SETPAR) begin
              drive_cyl_next[sel_next]   = {cmd_bytes[6][1:0], cmd_bytes[7]};
              drive_heads_next[sel_next] = cmd_bytes[8][4:0];
              ecc_len_next[sel_next]     = cmd_bytes[13];
            end
            if (test) begin
              rdy = (32'(sel_next) < DRIVES_PER_BOARD) && cfg.drive_present[sel_next];
              if (!rdy) begin
                status_byte_next = status_byte_next | SB_ERROR;
                error_code_next  = error_code_next | EC_NREADY;
              end else if (xfer) begin
                res_next.xfer_start = 1'b1;
                res_next.xfer_write = wr;
                res_next.xfer_pio   = op.pio;
                res_next.xfer_drive = sel_next;
                res_next.xfer_count = cur_cnt_next[sel_next];
              end
            end
          end
          res_bytes_next[n] = status_byte_next;
          n = n + 3'd1;
          if ((status_byte_next & SB_ERROR) != 8'd0) begin
            res_bytes_next[n] = error_code_next;
            n = n + 3'd1;
            if (error_code_next[7] && n <= 3'd2) begin
              res_bytes_next[n] = {2'b00, sel_next, cur_head_next[sel_next]};
              res_bytes_next[n + 3'd1] = {cur_cyl_next[sel_next][9:8], cur_sec_next[sel_next]};
              res_bytes_next[n + 3'd2] = cur_cyl_next[sel_next][7:0];
              n = n + 3'd3;
            end
          end
          bytes_left_next  = {1'b0, n};
          byte_ptr_next    = 4'd0;
          status_bits_next = status_bits | ST_INTERRUPT | ST_INPUT | ST_REQUEST
                             | ST_COMMAND | ST_READY;
          res_next.irq_pulse = 1'b1;
        end
      end
      default: res_next.read_data = cfg.dip_switches;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      out_valid   <= 1'b0;
      status_bits <= ST_COMMAND | ST_READY;
      bytes_left  <= 4'd0;
      byte_ptr    <= 4'd0;
      cmd_wait    <= 1'b0;
      status_byte <= 8'd0;
      error_code  <= 8'd0;
      sel         <= 1'b0;
      for (int i = 0; i < NDRV; i++) begin
        drive_cyl[i]   <= 10'd612;
        drive_heads[i] <= 5'd4;
        ecc_len[i]     <= 8'd11;
        cur_cyl[i]     <= '0;
        cur_head[i]    <= '0;
        cur_sec[i]     <= '0;
        cur_cnt[i]     <= '0;
      end
    end else begin
      // drop valid after a transfer unless a new result is loaded this edge
      if (out_valid && out_ready && !(op_pop && !res_next.xfer_start)) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (op_pop) begin
            status_bits <= status_bits_next;
            bytes_left  <= bytes_left_next;
            byte_ptr    <= byte_ptr_next;
            cmd_wait    <= cmd_wait_next;
            status_byte <= status_byte_next;
            error_code  <= error_code_next;
            sel         <= sel_next;
            drive_cyl   <= drive_cyl_next;
            drive_heads <= drive_heads_next;
            ecc_len     <= ecc_len_next;
            cur_cyl     <= cur_cyl_next;
            cur_head    <= cur_head_next;
            cur_sec     <= cur_sec_next;
            cur_cnt     <= cur_cnt_next;
            if (res_next.xfer_start) st <= S_MUL1;
            else out_valid <= 1'b1;
          end
        end
        S_MUL1: st <= S_MUL2;
        S_MUL2: st <= S_ADD;
        S_ADD: begin
          st        <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // payload: command/result byte stores, result register, sector datapath
  always_ff @(posedge clk) begin
    if (op_pop) begin
      cmd_bytes <= cmd_bytes_next;
      res_bytes <= res_bytes_next;
      res       <= res_next;
    end
    p1 <= cur_cyl[res.xfer_drive] * drive_heads[res.xfer_drive];
    p2 <= ({1'b0, p1} + 16'(cur_head[res.xfer_drive])) * cfg.spt;
    if (st == S_ADD)
      res.xfer_sector <= 21'(p2 + 22'(cur_sec[res.xfer_drive]));
  end

endmodule

### rtl/dcc_checker.sv
// Port-level checks of the disk controller command port, bound to the top level.
`timescale 1ns / 1ps
module dcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_irq_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:9] == 3'd5 || m_tdata[11:9] == 3'd2))
    else $error("bad interrupt line");

  a_no_xfer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[12] |-> m_tdata[44:13] == 32'd0)
    else $error("transfer fields set without request");

  a_xfer_irq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> m_tdata[8] && m_tdata[7:0] == 8'hff)
    else $error("transfer request outside a completed command");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind disk_controller_command_port dcc_checker u_dcc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### verif/disk_controller_command_port_test.sv
// Self-checking testbench for the disk controller command port.
`timescale 1ns / 1ps
module disk_controller_command_port_test;
  import dcc_pkg::*;

  // kinds six and seven are spare port decodes that return the switch byte
  localparam logic [2:0] K_SPARE_6 = 3'd6;
  localparam logic [2:0] K_SPARE_7 = 3'd7;
  // accepted by the decoder but executes as a no-op
  localparam logic [7:0] C_DIAG_E0 = 8'he0;
  localparam logic [7:0] C_BOGUS   = 8'hff;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] wbyte;
    logic       pio;
  } host_access_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] write_data, [8] dma_masked, rest zero
  logic [2:0]  s_tuser;   // [2:0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [7:0] read_data, [8] irq_pulse, [11:9] irq_level,
                          // [12] xfer_start, [13] xfer_write, [14] xfer_pio,
                          // [15] xfer_drive, [36:16] xfer_sector, [44:37] xfer_count
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  disk_controller_command_port DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the controller's registers
  // ---------------------------------------------------------------------
  logic [1:0]  present_cfg;
  logic [7:0]  dip_cfg;
  logic [5:0]  spt_cfg;

  logic [5:0]  hs_bits;          // host handshake status
  logic [7:0]  cmd_blk [14];
  logic [7:0]  res_blk [5];
  int unsigned bytes_due;
  int unsigned blk_ptr;
  bit          cmd_armed;        // full block waiting for its delay tick
  logic [7:0]  drv_status;
  logic [7:0]  err_code;
  logic        sel_drv;
  int unsigned geo_cyls [2], geo_heads [2], geo_rcc [2], geo_pcc [2], geo_ecc [2];
  int unsigned pos_cyl [2], pos_head [2], pos_sec [2], pos_cnt [2], pos_ctl [2];

  host_access_t pending_access [$];
  res_t         expected_res [$];
  int           errors;
  int unsigned  accepted_cnt;
  bit           in_taken;
  int unsigned  idle_pct;
  int unsigned  hold_left;
  bit           hold_done;

  function void clear_bytes();
    for (int i = 0; i < 14; i++) cmd_blk[i] = 8'h00;
    for (int i = 0; i < 5; i++) res_blk[i] = 8'h00;
  endfunction

  function void model_reset();
    present_cfg = 2'd0;
    dip_cfg     = 8'hff;
    spt_cfg     = 6'd17;
    hs_bits     = ST_COMMAND | ST_READY;
    clear_bytes();
    bytes_due = 0; blk_ptr = 0; cmd_armed = 0;
    drv_status = 8'h00; err_code = 8'h00; sel_drv = 1'b0;
    for (int d = 0; d < 2; d++) begin
      geo_cyls[d] = 612; geo_heads[d] = 4; geo_rcc[d] = 613; geo_pcc[d] = 613;
      geo_ecc[d] = 11;
      pos_cyl[d] = 0; pos_head[d] = 0; pos_sec[d] = 0; pos_cnt[d] = 0; pos_ctl[d] = 0;
    end
  endfunction

  // Queue status, error and sense bytes behind n leading bytes.
  function void post_results(int unsigned n);
    int unsigned d;
    d = sel_drv;
    res_blk[n] = drv_status; n++;
    if ((drv_status & SB_ERROR) != 0) begin
      res_blk[n] = err_code; n++;
      if (err_code[7] && n <= 2) begin
        res_blk[n]     = 8'((d << 5) | pos_head[d]);
        res_blk[n + 1] = 8'(((pos_cyl[d] >> 2) & 8'hc0) | pos_sec[d]);
        res_blk[n + 2] = 8'(pos_cyl[d] & 8'hff);
        n += 3;
      end
    end
    bytes_due = n;
    blk_ptr   = 0;
    hs_bits  |= ST_INTERRUPT | ST_INPUT | ST_REQUEST | ST_COMMAND | ST_READY;
  endfunction

  function void run_block(input logic pio, inout res_t r);
    logic [7:0]  op;
    int unsigned n, d, lin;
    bit pos, test, xfer, wr, skip;
    op = cmd_blk[0];
    n = 0; pos = 1; test = 1; xfer = 0; wr = 0; skip = 0;
    cmd_armed = 0; drv_status = 8'h00; err_code = 8'h00;
    case (op)
      C_TEST, C_SENSE: pos = 0;
      C_RECAL, C_SETPAR: test = 0;
      C_FMTDRV, C_VERIFY, C_FMTTRK, C_FMTBAD, C_SEEK, C_RDDIAG: ;
      C_READ, C_RDLONG: xfer = 1;
      C_WRITE, C_WRLONG: begin xfer = 1; wr = 1; end
      C_GETECC: begin
        // ECC length of the previously selected drive leads the results
        res_blk[0] = 8'(geo_ecc[sel_drv]);
        n = 1; skip = 1;
      end
      default: skip = 1;
    endcase
    if (!skip) begin
      sel_drv    = cmd_blk[1][5];
      drv_status = sel_drv ? SB_DRIVE1 : 8'h00;
      d = sel_drv;
      if (pos) begin
        pos_head[d] = cmd_blk[1][4:0];
        pos_sec[d]  = cmd_blk[2][5:0];
        pos_cyl[d]  = {cmd_blk[2][7:6], cmd_blk[3]};
        pos_cnt[d]  = cmd_blk[4];
        pos_ctl[d]  = cmd_blk[5];
        err_code    = EC_SENSE;
      end
      if (op == C_SETPAR) begin
        geo_cyls[d]  = {cmd_blk[6][1:0], cmd_blk[7]};
        geo_heads[d] = cmd_blk[8][4:0];
        geo_rcc[d]   = {cmd_blk[9][1:0], cmd_blk[10]};
        geo_pcc[d]   = {cmd_blk[11][1:0], cmd_blk[12]};
        geo_ecc[d]   = cmd_blk[13];
      end
      if (test) begin
        if (!(d < DRIVES_PER_BOARD && present_cfg[d])) begin
          drv_status |= SB_ERROR;
          err_code   |= EC_NREADY;
        end else if (xfer) begin
          lin = (pos_cyl[d] * geo_heads[d] + pos_head[d]) * spt_cfg + pos_sec[d];
          r.xfer_start  = 1'b1;
          r.xfer_write  = wr;
          r.xfer_pio    = pio;
          r.xfer_drive  = d[0];
          r.xfer_sector = lin[20:0];
          r.xfer_count  = 8'(pos_cnt[d]);
        end
      end
    end
    post_results(n);
    r.irq_pulse = 1'b1;
  endfunction

  function void host_write(input logic [7:0] v);
    bit known;
    if (bytes_due != 0 && (hs_bits & ST_INPUT) != 0) return;   // results pending
    if (bytes_due == 0) begin
      if (v <= 8'h0f) known = (v != 8'h02) && (v != 8'h09);
      else known = (v == C_DIAG_E0) || (v >= C_RDDIAG && v <= C_WRLONG);
      cmd_armed = 0;
      blk_ptr   = 0;
      hs_bits  &= ~(ST_READY | ST_INPUT);
      if (!known) begin
        drv_status = SB_ERROR | EC_BADCMD;
        err_code   = EC_BADCMD;
        post_results(0);
        return;
      end
      bytes_due = (v == C_SETPAR) ? 14 : 6;
      hs_bits  |= ST_REQUEST;
    end
    if (blk_ptr < 14) cmd_blk[blk_ptr] = v;
    blk_ptr = (blk_ptr + 1) & 15;
    hs_bits |= ST_READY;
    bytes_due--;
    if (bytes_due == 0) begin
      hs_bits  &= ~(ST_COMMAND | ST_REQUEST | ST_READY);
      hs_bits  |= ST_INPUT;
      cmd_armed = 1;
    end
  endfunction

  function logic [7:0] host_read();
    logic [7:0] v;
    if (bytes_due == 0 || (hs_bits & ST_INPUT) == 0) return 8'hff;
    v = (blk_ptr < 5) ? res_blk[blk_ptr] : 8'hff;
    blk_ptr  = (blk_ptr + 1) & 15;
    hs_bits &= ~ST_INTERRUPT;
    bytes_due--;
    if (bytes_due == 0) begin
      hs_bits &= ~(ST_INPUT | ST_REQUEST | ST_SELECT);
      hs_bits |= ST_COMMAND;
    end
    return v;
  endfunction

  function res_t predict_access(input host_access_t a);
    res_t r;
    r = '0;
    r.read_data = 8'hff;
    r.irq_level = dip_cfg[6] ? 3'd5 : 3'd2;
    case (a.kind)
      K_DATA_WR: host_write(a.wbyte);
      K_DATA_RD: r.read_data = host_read();
      K_STAT_RD: r.read_data = {2'b00, hs_bits};
      K_SEL_WR: begin
        hs_bits &= ~ST_INTERRUPT;
        hs_bits |= ST_SELECT;
      end
      K_RST_WR: begin
        // geometry survives a host reset, positions and queues do not
        for (int d = 0; d < 2; d++) begin
          pos_cyl[d] = 0; pos_head[d] = 0; pos_sec[d] = 0;
        end
        drv_status = 8'h00;
        hs_bits    = ST_COMMAND | ST_READY;
        clear_bytes();
        bytes_due = 0; blk_ptr = 0; cmd_armed = 0;
      end
      K_DELAY: if (cmd_armed) run_block(a.pio, r);
      default: r.read_data = dip_cfg;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset and run limit
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Host access driver: one nonblocking update of tvalid per falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    host_access_t a;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_access.size() > 0 && $urandom_range(99) >= idle_pct) begin
        a = pending_access.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, a.pio, a.wbyte};
        s_tuser  <= a.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off to fill the pipe
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (accepted_cnt >= 300 && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // a quiet stretch with no idling on either side
  always @(posedge clk) idle_pct = (accepted_cnt >= 600 && accepted_cnt < 850) ? 0 : 21;

  function void check_field(string nm, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h", $time, nm, e, a);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: check result transfers, then predict accepted input transfers
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    res_t e;
    host_access_t a;
    in_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_tdata);
          errors++;
        end else begin
          e = expected_res.pop_front();
          check_field("read_data",   32'(e.read_data),   32'(m_tdata[7:0]));
          check_field("irq_pulse",   32'(e.irq_pulse),   32'(m_tdata[8]));
          check_field("irq_level",   32'(e.irq_level),   32'(m_tdata[11:9]));
          check_field("xfer_start",  32'(e.xfer_start),  32'(m_tdata[12]));
          check_field("xfer_write",  32'(e.xfer_write),  32'(m_tdata[13]));
          check_field("xfer_pio",    32'(e.xfer_pio),    32'(m_tdata[14]));
          check_field("xfer_drive",  32'(e.xfer_drive),  32'(m_tdata[15]));
          check_field("xfer_sector", 32'(e.xfer_sector), 32'(m_tdata[36:16]));
          check_field("xfer_count",  32'(e.xfer_count),  32'(m_tdata[44:37]));
        end
      end
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        a.kind  = s_tuser;
        a.wbyte = s_tdata[7:0];
        a.pio   = s_tdata[8];
        expected_res.push_back(predict_access(a));
        accepted_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push(input logic [2:0] k, input logic [7:0] v = 8'h00, input logic p = 1'b0);
    host_access_t a;
    a.kind = k; a.wbyte = v; a.pio = p;
    pending_access.push_back(a);
  endtask

  // Full command block with random operands; drive byte and geometry random.
  task automatic push_block(input logic [7:0] op);
    int unsigned len;
    len = (op == C_SETPAR) ? 14 : 6;
    push(K_DATA_WR, op);
    for (int i = 1; i < len; i++) push(K_DATA_WR, 8'($urandom));
  endtask

  task automatic wait_idle();
    while (pending_access.size() > 0 || expected_res.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      R_PRESENT: present_cfg = v[1:0];
      R_DIP:     dip_cfg     = v[7:0];
      default:   spt_cfg     = v[5:0];
    endcase
  endtask

  task automatic random_traffic(input int unsigned n_items);
    logic [7:0] ops [16];
    logic [7:0] op;
    int unsigned start;
    ops = '{C_TEST, C_RECAL, C_SENSE, C_FMTDRV, C_VERIFY, C_FMTTRK, C_FMTBAD, C_READ,
            C_WRITE, C_SEEK, C_SETPAR, C_GETECC, C_RDDIAG, C_RDLONG, C_WRLONG, C_DIAG_E0};
    start = pending_access.size();
    while (pending_access.size() - start < n_items) begin
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(9))
          0, 1, 2: op = $urandom_range(1) ? C_READ : C_WRITE;
          3:       op = $urandom_range(1) ? C_RDLONG : C_WRLONG;
          4:       op = 8'($urandom);
          default: op = ops[$urandom_range(15)];
        endcase
        push_block(op);
        if ($urandom_range(3) == 0) push(K_STAT_RD);
        if ($urandom_range(9) == 0) push(K_RST_WR);        // broken sequence
        push(K_DELAY, 8'($urandom), 1'($urandom));
        if ($urandom_range(4) == 0) push(K_SEL_WR);
        repeat ($urandom_range(6)) push(K_DATA_RD);
      end else begin
        push(3'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    errors = 0; accepted_cnt = 0; in_taken = 0; idle_pct = 21;
    hold_left = 0; hold_done = 0;
    model_reset();
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle reads, spare kinds, bad opcode, missing drive with sense
    push(K_STAT_RD);
    push(K_SPARE_6);
    push(K_SPARE_7, 8'hff, 1'b1);
    push(K_DATA_RD);
    push(K_DELAY);                       // tick with nothing armed
    push(K_DATA_WR, C_BOGUS);            // unknown opcode answers at once
    push(K_DATA_WR, 8'h00);              // ignored while results pend
    push(K_DATA_RD);
    push(K_DATA_RD);
    push(K_SEL_WR);
    push(K_DATA_WR, C_READ); push(K_DATA_WR, 8'h3f); push(K_DATA_WR, 8'hff);
    push(K_DATA_WR, 8'hff);  push(K_DATA_WR, 8'h00); push(K_DATA_WR, 8'h00);
    push(K_STAT_RD);
    push(K_DELAY, 8'h00, 1'b1);
    repeat (5) push(K_DATA_RD);
    push(K_RST_WR);
    push(K_STAT_RD);
    wait_idle();

    // present drives, IRQ 2, widest geometry
    reg_write(R_PRESENT, 32'd3);
    reg_write(R_DIP, 32'h00);
    reg_write(R_SPT, 32'd63);
    push_block(C_SETPAR); push(K_DELAY); push(K_DATA_RD);
    push_block(C_WRITE);  push(K_DELAY, 8'h00, 1'b1); push(K_DATA_RD);
    push_block(C_GETECC); push(K_DELAY); push(K_DATA_RD); push(K_DATA_RD);
    random_traffic(280);
    wait_idle();                         // sender pause: all results back

    reg_write(R_PRESENT, 32'd1);
    reg_write(R_DIP, 32'h40);
    reg_write(R_SPT, 32'd1);
    random_traffic(280);
    wait_idle();

    reg_write(R_PRESENT, 32'd2);
    reg_write(R_DIP, 32'($urandom_range(255)));
    reg_write(R_SPT, 32'($urandom_range(62) + 1));
    random_traffic(280);
    wait_idle();

    reg_write(R_PRESENT, 32'd0);
    reg_write(R_DIP, 32'hbf);
    reg_write(R_SPT, 32'd17);
    random_traffic(140);
    wait_idle();

    reg_write(R_PRESENT, 32'd3);
    reg_write(R_DIP, 32'hff);
    reg_write(R_SPT, 32'($urandom_range(62) + 1));
    random_traffic(280);
    wait_idle();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dcc_pkg.sv
rtl/dcc_front.sv
rtl/dcc_back.sv
rtl/disk_controller_command_port.sv
rtl/dcc_checker.sv
verif/disk_controller_command_port_test.sv
